FILE: rtl/core/pal_pkg.sv
`default_nettype none
package pal_pkg;

    // Number of cells in the row; the list holds at most this many words.
    localparam int CAPACITY = 16;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Compare width: wide enough for a position, the fill count and one more.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ   = 2'd0,
        FN_MODIFY = 2'd1,
        FN_INSERT = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Broadcast from the control to every cell of the row.
    typedef struct packed {
        logic               ins;
        logic               rem;
        logic               mdf;
        logic [CMP_W-1:0]   pos_m1;
        logic [DATA_W-1:0]  value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: rtl/core/pal_if.sv
`default_nettype none
interface pal_in_if
    import pal_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    pos;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output pos, output value, input ready);
    modport sink   (input valid, input func, input pos, input value, output ready);
endinterface

interface pal_out_if
    import pal_pkg::*;
;
    logic                valid;
    logic                ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]   status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, output data, output status, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/positional_array_list.sv
`default_nettype none
// Bounded ordered list of signed 32-bit words addressed by 1-based position,
// built as a row of CAPACITY cells, each holding one entry. A request reads,
// modifies, inserts or removes one entry and yields exactly one result
// carrying the old or removed word, a status (ok, full, empty, bad position)
// and the count held afterwards with empty and full flags. One request is
// taken per clock cycle: the cells shift or load in the same cycle as the
// request transfer, and the result appears in the output register on the
// next cycle. The output register only holds back new requests while its
// result waits and the sink is not ready; a result taken in the same cycle
// frees the slot, so the sustained rate is one transfer per cycle.
module positional_array_list
    import pal_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pal_in_if.sink     i_in,
    pal_out_if.source  o_out
);

    // Control and fill count.
    logic                r_valid;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    n_used;

    // Result register; the payload needs no reset.
    logic [DATA_W-1:0]   r_data;
    t_status             r_status;

    logic                w_accept;
    t_func               w_func;
    logic [CMP_W-1:0]    w_pos;
    logic [CMP_W-1:0]    w_used;
    logic                w_pos_in_list;
    logic                w_full;
    logic                w_empty;
    t_status             w_status;
    logic                w_ok;
    logic [DATA_W-1:0]   w_hit;
    t_cell_ctrl          w_ctrl;

    logic [DATA_W-1:0]   w_word     [CAPACITY];
    logic [DATA_W-1:0]   w_hit_word [CAPACITY];

    // A new request enters when the output slot is free or is being emptied.
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_func  = t_func'(i_in.func);
    assign w_pos   = CMP_W'(i_in.pos);
    assign w_used  = CMP_W'(r_used);
    assign w_full  = (r_used == CNT_W'(CAPACITY));
    assign w_empty = (r_used == '0);
    assign w_pos_in_list = (w_pos != '0) && (w_pos <= w_used);

    // Status follows the check order: full before position on insert,
    // empty before position on remove.
    always_comb begin
        w_status = ST_OK;
        case (w_func)
            FN_READ, FN_MODIFY: begin
                if (!w_pos_in_list) w_status = ST_BADPOS;
            end
            FN_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos == '0 || w_pos > w_used + CMP_W'(1)) begin
                    w_status = ST_BADPOS;
                end
            end
            FN_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_pos_in_list) begin
                    w_status = ST_BADPOS;
                end
            end
            default: w_status = ST_BADPOS;
        endcase
    end

    assign w_ok = (w_status == ST_OK);

    // Broadcast to the cells; a rejected request leaves every cell alone.
    always_comb begin
        w_ctrl.ins    = w_accept && w_ok && (w_func == FN_INSERT);
        w_ctrl.rem    = w_accept && w_ok && (w_func == FN_REMOVE);
        w_ctrl.mdf    = w_accept && w_ok && (w_func == FN_MODIFY);
        w_ctrl.pos_m1 = w_pos - CMP_W'(1);
        w_ctrl.value  = i_in.value;
    end

    always_comb begin
        n_used = r_used;
        if (w_ctrl.ins) begin
            n_used = r_used + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_used = r_used - CNT_W'(1);
        end
    end

    // The row of cells. Each cell sees its two neighbors; the ends see zero.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end

        pal_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctrl       (w_ctrl),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .o_word       (w_word[g]),
            .o_hit_word   (w_hit_word[g])
        );
    end

    // Only the cell at the requested position drives a nonzero word here.
    always_comb begin
        w_hit = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_hit = w_hit | w_hit_word[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= '0;
        end else begin
            if (w_accept) begin
                r_valid  <= 1'b1;
                r_used   <= n_used;
                r_status <= w_status;
                // Insert and every rejected request return zero.
                r_data   <= (w_ok && w_func != FN_INSERT) ? w_hit : '0;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // The count register already holds the value after the reported request.
    assign o_out.valid    = r_valid;
    assign o_out.data     = r_data;
    assign o_out.status   = r_status;
    assign o_out.count    = COUNT_W'(r_used);
    assign o_out.is_empty = (r_used == '0);
    assign o_out.is_full  = (r_used == CNT_W'(CAPACITY));

endmodule
`default_nettype wire

FILE: rtl/core/pal_cell.sv
`default_nettype none
module pal_cell
    import pal_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic [IDX_W-1:0]    i_index,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire logic [DATA_W-1:0]   i_left_word,
    input  wire logic [DATA_W-1:0]   i_right_word,
    output logic [DATA_W-1:0]        o_word,
    output logic [DATA_W-1:0]        o_hit_word
);

    logic [DATA_W-1:0] r_word;
    logic [DATA_W-1:0] n_word;
    logic [CMP_W-1:0]  w_idx;
    logic              w_at;
    logic              w_after;

    assign w_idx   = CMP_W'(i_index);
    assign w_at    = (w_idx == i_ctrl.pos_m1);
    assign w_after = (w_idx > i_ctrl.pos_m1);

    // Insert takes the word from the left, remove from the right.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (w_at) begin
                n_word = i_ctrl.value;
            end else if (w_after) begin
                n_word = i_left_word;
            end
        end else if (i_ctrl.rem) begin
            if (w_at || w_after) begin
                n_word = i_right_word;
            end
        end else if (i_ctrl.mdf) begin
            if (w_at) begin
                n_word = i_ctrl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_hit_word = w_at ? r_word : '0;

endmodule
`default_nettype wire
